// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define WWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define WWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/wwf_pkg.sv -----
// Package for the weighted window image filter: payload types and constants.
// Depends on nothing.
package wwf_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KERNEL = 2'd2;
  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;
  localparam int unsigned MaxHeight = 4096;

  typedef struct packed {
    logic              mode;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
    logic [7:0]        alpha_in;
    logic [4:0]        weight_index;
    logic signed [15:0] weight_value;
  } in_req_t;

  typedef struct packed {
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        was_filtered;
    logic        last_of_run;
  } out_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // register the accepted request
    logic wt_write;   // apply a weight write
    logic px_fetch;   // fetch step (line store RAMs read continuously)
    logic px_shift;   // shift window, write line store
    logic sum_clr;    // start weight sum recompute
    logic sum_step;   // add one table entry to the sum
    logic mac_clr;    // clear accumulators
    logic mac_step;   // one window tap
    logic div_start;  // start dividers
    logic out_filt;   // present filtered result
    logic out_copy;   // present border copy
    logic out_last;   // last_of_run value for presented result
    logic pos_adv;    // advance the pixel counters
  } wwf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_weight;
    logic interior;   // pixel completes an interior window
    logic border;     // pixel itself is a border pixel
    logic tap_last;   // current tap is last of window
    logic sum_last;   // current sum index is last
    logic div_done;
  } wwf_sts_t;
endpackage

// ----- rtl/wwf_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module wwf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/wwf_ctrl.sv -----
// Controller state machine of the weighted window image filter.
// Depends on wwf_pkg.
module wwf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_we,
  input  logic [wwf_pkg::CfgIdxW-1:0] cfg_idx,
  input  wwf_pkg::wwf_sts_t sts,
  output wwf_pkg::wwf_cmd_t cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_FETCH  = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_MAC    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_OUTF   = 4'd6;
  localparam logic [3:0] S_OUTC   = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_WAIT   = 4'd9;
  localparam logic [3:0] S_DSTART = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !cfg_we;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          if (cfg_idx == wwf_pkg::CFG_KERNEL) begin
            cmd.sum_clr = 1'b1;
            state_nxt   = S_SUM;
          end
        end else if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEC: begin
        if (sts.is_weight) begin
          cmd.wt_write = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.px_fetch = 1'b1;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.px_shift = 1'b1;
        cmd.mac_clr  = 1'b1;
        if (sts.interior) begin
          state_nxt = S_MAC;
        end else begin
          state_nxt = S_OUTC;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (sts.tap_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // The last product is still being added into the accumulators.
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.out_filt = 1'b1;
          cmd.out_last = !sts.border;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_OUTF;
        end
      end
      S_OUTF: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          if (sts.border) begin
            state_nxt = S_OUTC;
          end else begin
            cmd.pos_adv = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_OUTC: begin
        if (!ovalid_r) begin
          if (sts.border) begin
            cmd.out_copy = 1'b1;
            cmd.out_last = 1'b1;
            ovalid_nxt   = 1'b1;
          end else begin
            cmd.pos_adv = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else if (out_ready) begin
          ovalid_nxt  = 1'b0;
          cmd.pos_adv = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

// ----- rtl/wwf_div.sv -----
// Sequential restoring divider for one channel: rounded, saturated n/d.
// Depends on nothing.
module wwf_div #(
  parameter int unsigned NW = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic                 done,
  output logic [7:0]           quo
);
  // Computes floor((2n+d)/(2d)) with d made positive; 9 quotient bits then saturate.
  localparam int unsigned CW = $clog2(10);
  logic [NW+1:0] rem_r, rem_nxt;
  logic [NW+1:0] dv_r, dv_nxt;
  logic [8:0]    q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, neg_r, neg_nxt, big_r, big_nxt;
  logic signed [NW+1:0] n_s, d_s, t_s;
  logic [NW+1:0] trial;

  always_comb begin
    n_s = (den < 0) ? -{{2{num[NW-1]}}, num} : {{2{num[NW-1]}}, num};
    d_s = (den < 0) ? -{{2{den[NW-1]}}, den} : {{2{den[NW-1]}}, den};
    t_s = (n_s <<< 1) + d_s;
    trial = rem_r - (dv_r << cnt_r);
    rem_nxt = rem_r; dv_nxt = dv_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; big_nxt = big_r;
    if (start) begin
      rem_nxt  = t_s;
      dv_nxt   = d_s <<< 1;
      neg_nxt  = t_s < 0;
      big_nxt  = 1'b0;
      q_nxt    = '0;
      cnt_nxt  = CW'(9);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == CW'(9)) begin
        // Quotient of 512 or more saturates.
        big_nxt = rem_r >= (dv_r << 9);
      end else if (rem_r >= (dv_r << cnt_r)) begin
        rem_nxt       = trial;
        q_nxt[cnt_r]  = 1'b1;
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  assign done = !busy_r && !start;
  assign quo  = neg_r ? 8'd0 : ((big_r || q_r[8]) ? 8'hFF : q_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt; dv_r <= dv_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
    neg_r <= neg_nxt; big_r <= big_nxt;
  end
endmodule

// ----- rtl/wwf_dp.sv -----
// Datapath: line store, window, weight table, MAC, dividers, output register.
// Depends on wwf_pkg, wwf_ram and wwf_div.
module wwf_dp #(
  parameter int unsigned MAX_KERNEL = 5,
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wwf_pkg::in_req_t              in_data,
  input  logic                          cfg_we,
  input  logic [wwf_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [wwf_pkg::CfgDataW-1:0]  cfg_data,
  input  wwf_pkg::wwf_cmd_t             cmd,
  output wwf_pkg::wwf_sts_t             sts,
  output wwf_pkg::out_req_t             out_data
);
  localparam int unsigned Lines = MAX_KERNEL - 1;
  localparam int unsigned Taps = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned TapW = $clog2(Taps + 1);
  localparam int unsigned KW = $clog2(MAX_KERNEL + 1);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned SlotW = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int unsigned SumW = 16 + $clog2(Taps);
  localparam int unsigned AccW = 24 + $clog2(Taps) + 1;
  localparam int unsigned DivW = (AccW > SumW) ? AccW : SumW;

  logic [11:0] width_reg_r;
  logic [12:0] height_reg_r;
  logic [2:0]  ksize_reg_r;
  logic [KW-1:0] k_eff;
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [KW-1:0] half;

  always_comb begin
    logic [2:0] kk;
    kk = ksize_reg_r;
    if (kk == 3'd0) kk = 3'd1;
    if (32'(kk) > MAX_KERNEL) kk = 3'(MAX_KERNEL);
    if (!kk[0]) kk = kk - 3'd1;
    k_eff = KW'(kk);
    half  = k_eff >> 1;
    w_eff = (width_reg_r == '0) ? WW'(1)
          : ((32'(width_reg_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg_r));
    h_eff = (height_reg_r == '0) ? 13'd1
          : ((32'(height_reg_r) > wwf_pkg::MaxHeight) ? 13'(wwf_pkg::MaxHeight)
             : height_reg_r);
  end

  wwf_pkg::in_req_t req_r;
  logic [CW-1:0] col_r;
  logic [11:0]   row_r;
  logic [SlotW-1:0] slot_r;

  logic signed [15:0] wt_r [Taps];
  logic signed [SumW-1:0] wsum_r;
  logic [TapW-1:0] sidx_r;

  logic [31:0] win_r [MAX_KERNEL][MAX_KERNEL];
  logic [31:0] rd_data [Lines];
  logic [31:0] px;
  assign px = {req_r.alpha_in, req_r.blue_in, req_r.green_in, req_r.red_in};

  // One RAM per buffered line.
  for (genvar g = 0; g < Lines; g++) begin : g_line
    wwf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (cmd.px_shift && slot_r == SlotW'(g)),
      .waddr (col_r),
      .wdata (px),
      .raddr (col_r),
      .rdata (rd_data[g])
    );
  end

  // Tap walk over the active kernel.
  logic [KW-1:0] ti_r, tj_r;
  logic [TapW-1:0] tidx_r;
  logic signed [AccW-1:0] acc_r [4];
  logic [31:0] tap_px;
  logic signed [15:0] tap_wt;
  logic signed [24:0] prod_r [4];
  logic prod_v_r;

  assign tap_px = win_r[MAX_KERNEL - 32'(k_eff) + 32'(ti_r)]
                       [MAX_KERNEL - 32'(k_eff) + 32'(tj_r)];
  assign tap_wt = wt_r[tidx_r];

  logic interior, border;
  logic [3:0] dn;
  always_comb begin
    interior = (32'(row_r) >= 2 * 32'(half)) && (32'(col_r) >= 2 * 32'(half));
    border = (32'(row_r) < 32'(half)) || (32'(row_r) + 32'(half) >= 32'(h_eff))
          || (32'(col_r) < 32'(half)) || (32'(col_r) + 32'(half) >= 32'(w_eff));
  end

  always_comb begin
    sts.is_weight = req_r.mode == wwf_pkg::MODE_WEIGHT;
    sts.interior  = interior;
    sts.border    = border;
    sts.tap_last  = (ti_r == k_eff - KW'(1)) && (tj_r == k_eff - KW'(1));
    sts.sum_last  = 32'(sidx_r) + 1 >= 32'(k_eff) * 32'(k_eff);
    sts.div_done  = &dn;
  end

  logic [DivW-1:0] den;
  assign den = (wsum_r != '0) ? DivW'(wsum_r) : DivW'(1 << WEIGHT_FRAC_BITS);
  logic [7:0] quo [4];
  for (genvar q = 0; q < 4; q++) begin : g_div
    wwf_div #(.NW(DivW)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.div_start),
      .num   (DivW'(acc_r[q])),
      .den   (den),
      .done  (dn[q]),
      .quo   (quo[q])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_reg_r  <= 12'd640;
      height_reg_r <= 13'd480;
      ksize_reg_r  <= 3'd3;
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      wsum_r <= '0;
      for (int i = 0; i < Taps; i++) wt_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          wwf_pkg::CFG_WIDTH:  width_reg_r  <= cfg_data[11:0];
          wwf_pkg::CFG_HEIGHT: height_reg_r <= cfg_data;
          wwf_pkg::CFG_KERNEL: ksize_reg_r  <= cfg_data[2:0];
          default: ;
        endcase
        if (cfg_idx == wwf_pkg::CFG_WIDTH || cfg_idx == wwf_pkg::CFG_HEIGHT ||
            cfg_idx == wwf_pkg::CFG_KERNEL) begin
          col_r  <= '0;
          row_r  <= '0;
          slot_r <= '0;
        end
      end
      if (cmd.sum_clr) begin
        wsum_r <= '0;
      end
      if (cmd.sum_step) begin
        wsum_r <= wsum_r + SumW'(wt_r[sidx_r]);
      end
      if (cmd.wt_write && 32'(req_r.weight_index) < 32'(k_eff) * 32'(k_eff)) begin
        wt_r[req_r.weight_index] <= req_r.weight_value;
        wsum_r <= wsum_r + SumW'(req_r.weight_value) - SumW'(wt_r[req_r.weight_index]);
      end
      if (cmd.pos_adv) begin
        if (32'(col_r) + 1 >= 32'(w_eff)) begin
          col_r <= '0;
          if (32'(row_r) + 1 >= 32'(h_eff)) begin
            row_r  <= '0;
            slot_r <= '0;
          end else begin
            row_r  <= row_r + 12'd1;
            slot_r <= (32'(slot_r) + 1 >= Lines) ? '0 : slot_r + SlotW'(1);
          end
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.sum_clr) begin
      sidx_r <= '0;
    end else if (cmd.sum_step) begin
      sidx_r <= sidx_r + TapW'(1);
    end
    if (cmd.px_shift) begin
      for (int i = 0; i < MAX_KERNEL; i++)
        for (int j = 0; j + 1 < MAX_KERNEL; j++)
          win_r[i][j] <= win_r[i][j+1];
      win_r[MAX_KERNEL-1][MAX_KERNEL-1] <= px;
      for (int d = 1; d <= Lines; d++)
        win_r[MAX_KERNEL-1-d][MAX_KERNEL-1] <=
          rd_data[(32'(slot_r) + Lines - d) % Lines];
    end
    prod_v_r <= cmd.mac_step;
    if (cmd.mac_clr) begin
      ti_r <= '0; tj_r <= '0; tidx_r <= '0;
      for (int q = 0; q < 4; q++) acc_r[q] <= '0;
    end else begin
      if (cmd.mac_step) begin
        for (int q = 0; q < 4; q++)
          prod_r[q] <= $signed({1'b0, tap_px[8*q +: 8]}) * tap_wt;
        tidx_r <= tidx_r + TapW'(1);
        if (tj_r == k_eff - KW'(1)) begin
          tj_r <= '0;
          ti_r <= ti_r + KW'(1);
        end else begin
          tj_r <= tj_r + KW'(1);
        end
      end
      if (prod_v_r) begin
        for (int q = 0; q < 4; q++) acc_r[q] <= acc_r[q] + AccW'(prod_r[q]);
      end
    end
    if (cmd.out_filt) begin
      out_data <= '{out_col: 11'(col_r - CW'(half)), out_row: row_r - 12'(half),
                    red_out: quo[0], green_out: quo[1], blue_out: quo[2],
                    alpha_out: quo[3], was_filtered: 1'b1, last_of_run: cmd.out_last};
    end else if (cmd.out_copy) begin
      out_data <= '{out_col: 11'(col_r), out_row: row_r,
                    red_out: req_r.red_in, green_out: req_r.green_in,
                    blue_out: req_r.blue_in, alpha_out: req_r.alpha_in,
                    was_filtered: 1'b0, last_of_run: cmd.out_last};
    end
  end
endmodule

// ----- rtl/weighted_window_image_filter.sv -----
// Top level of the weighted window image filter.
// Depends on wwf_pkg, wwf_ctrl and wwf_dp.
//
// Normalized K x K RGBA convolution over a raster pixel stream. Each request is
// a pixel or a weight write (Q8.8). One request is handled at a time: a weight
// write updates the table; a border pixel is fetched, shifted into the window
// and copied out; a pixel completing an interior window goes through the
// one-tap-per-cycle multiply-accumulate walk over the window and the bit-serial
// dividers. Writing kernel_size recomputes the weight sum over the K*K entries.
// A filtered result precedes the border copy when one pixel causes both.
module weighted_window_image_filter #(
  parameter int unsigned MAX_KERNEL = 5,
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wwf_pkg::in_req_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wwf_pkg::out_req_t            out_data,
  input  logic                         cfg_we,
  input  logic [wwf_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [wwf_pkg::CfgDataW-1:0] cfg_data
);
  wwf_pkg::wwf_cmd_t cmd;
  wwf_pkg::wwf_sts_t sts;

  wwf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .sts(sts), .cmd(cmd)
  );

  wwf_dp #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );
endmodule

// ----- rtl/wwf_checker.sv -----
// Port-level checker for the weighted window image filter, with its bind.
// Depends on wwf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wwf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input wwf_pkg::out_req_t out_data
);
  `WWF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `WWF_ASSERT_IMPL(a_one_at_time, clk, rst_n, out_valid, !in_ready, "request taken while a result waits")
  `WWF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "two requests back to back")
  `WWF_ASSERT_IMPL(a_copy_last, clk, rst_n, out_valid && !out_data.was_filtered, out_data.last_of_run, "border copy not last")
endmodule

bind weighted_window_image_filter wwf_checker u_wwf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- tb/sv/weighted_window_image_filter_tb.sv -----
// Self-checking testbench for the weighted window image filter.
// Depends on wwf_pkg and weighted_window_image_filter; holds its own filter predictor.
module weighted_window_image_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wwf_pkg::*;

  localparam int ReqW = $bits(in_req_t);

  // Predicts the filtered and copied pixels of every accepted request and
  // checks each result the block hands out against the oldest prediction.
  class filter_scoreboard;
    bit [31:0] rows_held[4][2048];
    bit [31:0] window_px[5][5];
    int kernel_wt[25];
    int wt_total;
    int col_pos, row_pos;
    int reg_width, reg_height, reg_kernel;
    out_req_t pixels_due[$];
    int errors;

    function new();
      foreach (rows_held[i, j]) rows_held[i][j] = '0;
      foreach (window_px[i, j]) window_px[i][j] = '0;
      foreach (kernel_wt[i]) kernel_wt[i] = 0;
      wt_total = 0;
      col_pos = 0;
      row_pos = 0;
      reg_width = 640;
      reg_height = 480;
      reg_kernel = 3;
      errors = 0;
    endfunction

    function int side();
      int k;
      k = reg_kernel > 5 ? 5 : reg_kernel;
      if (k == 0) k = 1;
      if (k % 2 == 0) k = k - 1;
      return k;
    endfunction

    function int cols();
      return reg_width == 0 ? 1 : (reg_width > 2048 ? 2048 : reg_width);
    endfunction

    function int lines();
      return reg_height == 0 ? 1 : (reg_height > MaxHeight ? MaxHeight : reg_height);
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, int val);
      int k;
      case (idx)
        CFG_WIDTH: reg_width = val & 12'hFFF;
        CFG_HEIGHT: reg_height = val & 13'h1FFF;
        CFG_KERNEL: begin
          reg_kernel = val & 3'h7;
          k = side();
          wt_total = 0;
          for (int i = 0; i < k * k; i++) wt_total += kernel_wt[i];
        end
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    // Rounded to nearest (ties up) and clamped to 0..255.
    function logic [7:0] norm_round(longint num, longint den);
      longint t;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      t = 2 * num + den;
      if (t < 0) return 8'd0;
      t = t / (2 * den);
      return t > 255 ? 8'd255 : t[7:0];
    endfunction

    function void note_input(in_req_t req);
      int k, h, base;
      bit [31:0] px;
      longint acc[4];
      longint div;
      out_req_t res;
      int made;
      k = side();
      h = k / 2;
      made = 0;
      if (req.mode == MODE_WEIGHT) begin
        if (req.weight_index < k * k) begin
          wt_total += int'(req.weight_value) - kernel_wt[req.weight_index];
          kernel_wt[req.weight_index] = int'(req.weight_value);
        end
        return;
      end
      px = {req.alpha_in, req.blue_in, req.green_in, req.red_in};
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 4; j++) window_px[i][j] = window_px[i][j + 1];
      window_px[4][4] = px;
      for (int d = 1; d <= 4; d++)
        window_px[4 - d][4] = rows_held[((row_pos % 4) + 4 - d) % 4][col_pos];
      rows_held[row_pos % 4][col_pos] = px;

      if (row_pos >= 2 * h && col_pos >= 2 * h) begin
        acc = '{0, 0, 0, 0};
        div = wt_total != 0 ? longint'(wt_total) : 64'd256;
        base = 5 - k;
        for (int i = 0; i < k; i++)
          for (int j = 0; j < k; j++)
            for (int q = 0; q < 4; q++)
              acc[q] += longint'(window_px[base + i][base + j][8 * q +: 8]) *
                        longint'(kernel_wt[i * k + j]);
        res.out_col = col_pos - h;
        res.out_row = row_pos - h;
        res.red_out = norm_round(acc[0], div);
        res.green_out = norm_round(acc[1], div);
        res.blue_out = norm_round(acc[2], div);
        res.alpha_out = norm_round(acc[3], div);
        res.was_filtered = 1'b1;
        res.last_of_run = 1'b0;
        pixels_due.push_back(res);
        made++;
      end
      if (row_pos < h || row_pos + h >= lines() || col_pos < h || col_pos + h >= cols()) begin
        res.out_col = col_pos;
        res.out_row = row_pos;
        res.red_out = req.red_in;
        res.green_out = req.green_in;
        res.blue_out = req.blue_in;
        res.alpha_out = req.alpha_in;
        res.was_filtered = 1'b0;
        res.last_of_run = 1'b0;
        pixels_due.push_back(res);
        made++;
      end
      if (made > 0) begin
        res = pixels_due.pop_back();
        res.last_of_run = 1'b1;
        pixels_due.push_back(res);
      end
      col_pos++;
      if (col_pos >= cols()) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= lines()) row_pos = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(out_req_t got);
      out_req_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pixels_due.pop_front();
      if ($isunknown(got)) report($sformatf("unknown bits in result %h", got));
      check_field("out_col", got.out_col, want.out_col);
      check_field("out_row", got.out_row, want.out_row);
      check_field("red_out", got.red_out, want.red_out);
      check_field("green_out", got.green_out, want.green_out);
      check_field("blue_out", got.blue_out, want.blue_out);
      check_field("alpha_out", got.alpha_out, want.alpha_out);
      check_field("was_filtered", got.was_filtered, want.was_filtered);
      check_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CFG_WIDTH;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Idle percentages for each side, and a request counter for long receiver
  // hold-offs; the percentages and the counter are written by the stimulus process.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_asked = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  filter_scoreboard sb = new();

  always #4 clk = ~clk;

  weighted_window_image_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Monitor and watchdog. An accepted input is predicted before the
  // result of the same edge is checked; a result never comes from an input
  // taken at the same edge, so the order is harmless.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

    // Nothing moving on either channel for this long means the block hung.
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver either follows its stall percentage or, when the
  // stimulus asks for it, holds off for a long stretch of cycles.
  always @(posedge clk) begin
    if (holdoff_asked != holdoff_seen) begin
      holdoff_seen <= holdoff_asked;
      holdoff_left <= 400;
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that a following request goes out without a bubble.
  task automatic send_req(in_req_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    if (req.mode == MODE_PIXEL || req.weight_index < sb.side() * sb.side()) items_sent++;
  endtask

  // Lowers valid and waits until every predicted pixel has come out, then
  // lets a weight write or a weight-sum pass still in flight finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // All three registers are written on back-to-back edges while idle.
  task automatic write_cfg(int w, int h, int k);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WIDTH;
    cfg_data <= CfgDataW'(w);
    @(posedge clk);
    sb.set_reg(CFG_WIDTH, w);
    cfg_idx <= CFG_HEIGHT;
    cfg_data <= CfgDataW'(h);
    @(posedge clk);
    sb.set_reg(CFG_HEIGHT, h);
    cfg_idx <= CFG_KERNEL;
    cfg_data <= CfgDataW'(k);
    @(posedge clk);
    sb.set_reg(CFG_KERNEL, k);
    cfg_we <= 1'b0;
  endtask

  function automatic in_req_t pixel_req(bit [31:0] px);
    in_req_t r;
    r = in_req_t'(ReqW'($urandom_range(0, 1 << 20)));
    r.mode = MODE_PIXEL;
    {r.alpha_in, r.blue_in, r.green_in, r.red_in} = px;
    return r;
  endfunction

  function automatic in_req_t weight_req(int idx, int val);
    in_req_t r;
    r = in_req_t'(ReqW'({$urandom, $urandom}));
    r.mode = MODE_WEIGHT;
    r.weight_index = 5'(idx);
    r.weight_value = 16'(val);
    return r;
  endfunction

  initial begin
    int k, w, h, wi, hi, npix, scheme, phase, last_wt;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a 4 x 4 frame with a 3 x 3 kernel, extreme weights, ignored
    // weight indexes and pixels at the channel extremes.
    write_cfg(4, 4, 3);
    send_req(weight_req(0, 16'sh7FFF));
    send_req(weight_req(1, -32768));
    send_req(weight_req(4, 256));
    send_req(weight_req(9, 1000));
    send_req(weight_req(31, -5));
    for (int i = 0; i < 16; i++)
      send_req(pixel_req(i % 2 ? 32'hFFFF_FFFF : (i % 3 ? 32'h00FF_00FF : 32'h0)));

    // Random phases: a new geometry, a fresh kernel and a frame or so of pixels
    // each (40 to 120 for larger frames), the idling pattern rotating by phase.
    phase = 0;
    while (items_sent < 1800) begin
      case (phase % 4)
        0: begin send_gap_pct = 0; recv_stall_pct = 0; end
        1: begin send_gap_pct = 88; recv_stall_pct = 0; end
        2: begin send_gap_pct = 0; recv_stall_pct = 88; end
        default: begin send_gap_pct = 14; recv_stall_pct = 14; end
      endcase
      case ($urandom_range(19))
        0: w = 0;
        1: w = 2048;
        2: w = 4095;
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(19))
        0: h = 0;
        1: h = 4096;
        2: h = 8191;
        default: h = $urandom_range(1, 10);
      endcase
      k = phase < 8 ? phase : $urandom_range(0, 7);
      write_cfg(w, h, k);
      k = sb.side();
      wi = sb.cols();
      hi = sb.lines();

      // Weight schemes: all zero, small positive, full range, and signed
      // pairs that cancel so that the divisor falls back to one.
      scheme = $urandom_range(3);
      last_wt = 0;
      for (int i = 0; i < k * k; i++) begin
        case (scheme)
          0: last_wt = 0;
          1: last_wt = $urandom_range(0, 300);
          2: last_wt = $signed(16'($urandom));
          default: last_wt = (i % 2) ? -last_wt : $signed(16'($urandom));
        endcase
        if (scheme == 3 && i == k * k - 1) last_wt = 0;
        send_req(weight_req(i, last_wt));
      end
      send_req(weight_req($urandom_range(k * k, 31), $signed(16'($urandom))));

      // A long receiver hold-off while the sender keeps offering pixels.
      if (phase % 10 == 2) holdoff_asked++;

      npix = (wi * hi <= 120) ? wi * hi + $urandom_range(0, wi < 8 ? wi : 8)
                              : $urandom_range(40, 120);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(99) < 4)
          send_req(weight_req($urandom_range(0, 31), $signed(16'($urandom))));
        send_req(pixel_req($urandom));
      end
      phase++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wwf_pkg.sv
rtl/wwf_ram.sv
rtl/wwf_ctrl.sv
rtl/wwf_div.sv
rtl/wwf_dp.sv
rtl/weighted_window_image_filter.sv
rtl/wwf_checker.sv
tb/sv/weighted_window_image_filter_tb.sv
